// File: rtl/core/fis_pkg.sv
// fis_pkg: widths, constants, state encoding and result word of the frame interval statistics
// no dependencies; compiled first
package fis_pkg;

  localparam int STAMP_W   = 64;
  localparam int DT_W      = 32;
  localparam int RATE_W    = 24;
  localparam int TARGET_W  = 30;
  localparam int ACC_W     = 33;
  localparam int STEPS_W   = 3;
  localparam int DIGIT_W   = 4;
  localparam int AVG_NUM_W = 37;

  localparam int RATE_FRAC_BITS_DEF = 8;

  localparam logic [TARGET_W-1:0] TARGET_RESET    = 30'd16666667;
  localparam logic [DT_W-1:0]     NO_TARGET_LIMIT = 32'd100000000;
  localparam logic [TARGET_W-1:0] NS_PER_SEC      = 30'd1000000000;
  localparam logic [RATE_W-1:0]   RATE_MAX        = '1;
  localparam logic [DT_W-1:0]     RATE_AVG_DIV    = 32'd10;
  localparam logic [DT_W-1:0]     RATE_AVG_ROUND  = 32'd5;
  localparam logic [DT_W-1:0]     DT_AVG_DIV      = 32'd20;
  localparam logic [DT_W-1:0]     DT_AVG_ROUND    = 32'd10;
  localparam logic [STEPS_W-1:0]  MAX_STEPS       = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_CLAMP,
    ST_STATS,
    ST_TOTAL,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_RAVG_GO,
    ST_RAVG_WAIT,
    ST_IAVG_GO,
    ST_IAVG_WAIT,
    ST_STEP_SUM,
    ST_STEP_CLIP,
    ST_STEP_DRAIN,
    ST_OUTPUT
  } fis_state_t;

  typedef struct packed {
    logic [DT_W-1:0]    frame_dt_ns;
    logic [DT_W-1:0]    raw_dt_ns;
    logic [RATE_W-1:0]  smoothed_rate_q8;
    logic [DT_W-1:0]    min_dt_ns;
    logic [DT_W-1:0]    max_dt_ns;
    logic [DT_W-1:0]    avg_dt_ns;
    logic [STAMP_W-1:0] total_time_ns;
    logic [DT_W-1:0]    frame_number;
    logic [STEPS_W-1:0] fixed_steps;
    logic               hitch;
  } fis_result_t;

endpackage

// File: rtl/core/fis_channels.sv
// fis channels: valid/ready interfaces for timestamp words, result words and the target register
// depends on fis_pkg
interface fis_stamp_if;
  import fis_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] timestamp_ns;
  modport source (output valid, output timestamp_ns, input ready);
  modport sink (input valid, input timestamp_ns, output ready);
endinterface

interface fis_result_if;
  import fis_pkg::*;
  logic               valid;
  logic               ready;
  logic [DT_W-1:0]    frame_dt_ns;
  logic [DT_W-1:0]    raw_dt_ns;
  logic [RATE_W-1:0]  smoothed_rate_q8;
  logic [DT_W-1:0]    min_dt_ns;
  logic [DT_W-1:0]    max_dt_ns;
  logic [DT_W-1:0]    avg_dt_ns;
  logic [STAMP_W-1:0] total_time_ns;
  logic [DT_W-1:0]    frame_number;
  logic [STEPS_W-1:0] fixed_steps;
  logic               hitch;
  modport source (output valid, output frame_dt_ns, output raw_dt_ns,
                  output smoothed_rate_q8, output min_dt_ns, output max_dt_ns,
                  output avg_dt_ns, output total_time_ns, output frame_number,
                  output fixed_steps, output hitch, input ready);
  modport sink (input valid, input frame_dt_ns, input raw_dt_ns,
                input smoothed_rate_q8, input min_dt_ns, input max_dt_ns,
                input avg_dt_ns, input total_time_ns, input frame_number,
                input fixed_steps, input hitch, output ready);
endinterface

interface fis_cfg_if;
  import fis_pkg::*;
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_period_ns;
  modport source (output valid, output target_period_ns, input ready);
  modport sink (input valid, input target_period_ns, output ready);
endinterface

// File: rtl/core/fis_div.sv
// fis_div: restoring divider, one quotient bit per cycle
// standalone; instantiated by frame_interval_statistics
module fis_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;

  // next partial remainder and its trial subtraction
  assign shifted = {rem, quo_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign quo     = quo_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy) begin
      if (!trial[DEN_W+1]) begin
        rem   <= trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem   <= shifted[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/frame_interval_statistics.sv
// frame_interval_statistics: frame interval, clamp, min/max, moving averages and fixed steps
// depends on fis_pkg, fis_channels (interfaces) and fis_div
//
// usage
//   stamp  : one word per frame, the 64-bit frame time in ns; taken when valid and ready
//   result : one word per stamp word with clamped/raw interval, smoothed rate (q8),
//            min/max/average interval, total time, frame count, fixed steps and hitch
//   cfg    : write of the target period register; always ready, write only while idle
// timing
//   one stamp word at a time; a new word is taken only in the idle state, after the
//   previous result has been handed to the output register
//   interval and total time: each in a 4-bit digit-serial adder; rate, rate average
//   and interval average: each on one bit-serial divider; fixed-step drain: one period
//   removed per step; a zero interval skips the two rate divisions, a zero target
//   skips the step stage
// reset: synchronous, active high; statistics return to their start values, the target
//   period to 16666667 ns, and the result channel empties
// stall
//   the result sits in an output register; the next stamp word is taken and worked on
//   while it waits, and the block holds in its final state until the register frees up
module frame_interval_statistics #(
  parameter int RATE_FRAC_BITS = fis_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  fis_stamp_if.sink    stamp,
  fis_result_if.source result,
  fis_cfg_if.sink      cfg
);

  import fis_pkg::*;

  // divider wide enough for the scaled second and for the interval average numerator
  localparam int NUM_W = (TARGET_W + RATE_FRAC_BITS > AVG_NUM_W) ?
                         (TARGET_W + RATE_FRAC_BITS) : AVG_NUM_W;
  localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(NS_PER_SEC) << RATE_FRAC_BITS;
  localparam int DIGITS = STAMP_W / DIGIT_W;
  localparam int DCNT_W = $clog2(DIGITS);

  fis_state_t state, state_next;

  // configuration
  logic [TARGET_W-1:0] target;

  // running statistics
  logic [STAMP_W-1:0] last_stamp;
  logic               seen_first;
  logic [RATE_W-1:0]  rate_avg;
  logic [DT_W-1:0]    min_interval;
  logic [DT_W-1:0]    max_interval;
  logic [DT_W-1:0]    interval_avg;
  logic [STAMP_W-1:0] run_time;
  logic [DT_W-1:0]    frames_seen;
  logic [ACC_W-1:0]   step_accumulator;

  // per-word working registers
  logic [STAMP_W-1:0] op_a;
  logic [STAMP_W-1:0] op_b;
  logic               carry;
  logic [DCNT_W-1:0]  dcnt;
  logic [DT_W-1:0]    raw;
  logic [DT_W-1:0]    dt;
  logic [RATE_W-1:0]  inst;
  logic [ACC_W:0]     acc;
  logic [ACC_W-1:0]   cap;
  logic [STEPS_W-1:0] steps;
  logic               hitch;

  // output register
  logic        res_valid;
  fis_result_t res;

  // digit-serial adder
  logic [DIGIT_W:0]   dsum;
  logic [STAMP_W-1:0] op_a_next;
  logic               dlast;

  // clamp
  logic [DT_W-1:0] raw_c;
  logic [DT_W-1:0] limit_c;

  // divider hookup
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [DT_W-1:0]  div_den;
  logic [NUM_W-1:0] div_quo;

  assign dsum      = {1'b0, op_a[DIGIT_W-1:0]} + {1'b0, op_b[DIGIT_W-1:0]}
                   + {{DIGIT_W{1'b0}}, carry};
  assign op_a_next = {dsum[DIGIT_W-1:0], op_a[STAMP_W-1:DIGIT_W]};
  assign dlast     = (dcnt == DCNT_W'(DIGITS - 1));

  // raw interval saturates to 32 bits, then clamps to three periods or 100 ms
  assign raw_c   = (|op_a[STAMP_W-1:DT_W]) ? '1 : op_a[DT_W-1:0];
  assign limit_c = (target != '0) ?
                   (({2'b00, target} << 1) + {2'b00, target}) : NO_TARGET_LIMIT;

  assign stamp.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  // ---------------------------------------------------------------------------
  // shared divider: instant rate, rate average /10, interval average /20
  // ---------------------------------------------------------------------------
  always_comb begin
    div_start = 1'b0;
    div_num   = RATE_NUM;
    div_den   = dt;
    unique case (state)
      ST_RATE_GO: begin
        div_start = 1'b1;
      end
      ST_RAVG_GO: begin
        div_start = 1'b1;
        // 9*avg + instant + 5
        div_num   = (NUM_W'(rate_avg) << 3) + NUM_W'(rate_avg) + NUM_W'(inst)
                  + NUM_W'(RATE_AVG_ROUND);
        div_den   = RATE_AVG_DIV;
      end
      ST_IAVG_GO: begin
        div_start = 1'b1;
        // 19*avg + dt + 10
        div_num   = (NUM_W'(interval_avg) << 4) + (NUM_W'(interval_avg) << 1)
                  + NUM_W'(interval_avg) + NUM_W'(dt) + NUM_W'(DT_AVG_ROUND);
        div_den   = DT_AVG_DIV;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  fis_div #(
    .NUM_W(NUM_W),
    .DEN_W(DT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (stamp.valid) state_next = ST_DELTA;
      ST_DELTA:      if (dlast) state_next = ST_CLAMP;
      ST_CLAMP:      state_next = ST_STATS;
      ST_STATS:      state_next = ST_TOTAL;
      ST_TOTAL: begin
        // a zero interval leaves the rate average alone
        if (dlast) state_next = (dt != '0) ? ST_RATE_GO : ST_IAVG_GO;
      end
      ST_RATE_GO:    state_next = ST_RATE_WAIT;
      ST_RATE_WAIT:  if (div_done) state_next = ST_RAVG_GO;
      ST_RAVG_GO:    state_next = ST_RAVG_WAIT;
      ST_RAVG_WAIT:  if (div_done) state_next = ST_IAVG_GO;
      ST_IAVG_GO:    state_next = ST_IAVG_WAIT;
      ST_IAVG_WAIT: begin
        // no target period: accumulator holds, no steps
        if (div_done) state_next = (target != '0) ? ST_STEP_SUM : ST_OUTPUT;
      end
      ST_STEP_SUM:   state_next = ST_STEP_CLIP;
      ST_STEP_CLIP:  state_next = ST_STEP_DRAIN;
      ST_STEP_DRAIN: if (acc < {4'b0000, target}) state_next = ST_OUTPUT;
      ST_OUTPUT:     if (!res_valid || result.ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // target period register
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      target <= cfg.target_period_ns;
    end
  end

  // ---------------------------------------------------------------------------
  // statistics and per-word datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp       <= '0;
      seen_first       <= 1'b0;
      rate_avg         <= '0;
      min_interval     <= '1;
      max_interval     <= '0;
      interval_avg     <= DT_W'(TARGET_RESET);
      run_time         <= '0;
      frames_seen      <= '0;
      step_accumulator <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (stamp.valid) begin
            last_stamp <= stamp.timestamp_ns;
            seen_first <= 1'b1;
          end
        end
        ST_STATS: begin
          if (dt < min_interval) min_interval <= dt;
          if (dt > max_interval) max_interval <= dt;
          frames_seen <= frames_seen + 1'b1;
        end
        ST_TOTAL: begin
          if (dlast) run_time <= op_a_next;
        end
        ST_RAVG_WAIT: begin
          if (div_done) begin
            rate_avg <= (|div_quo[NUM_W-1:RATE_W]) ? RATE_MAX : div_quo[RATE_W-1:0];
          end
        end
        ST_IAVG_WAIT: begin
          if (div_done) interval_avg <= div_quo[DT_W-1:0];
        end
        ST_STEP_DRAIN: begin
          if (acc < {4'b0000, target}) step_accumulator <= acc[ACC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // difference as a + ~b + 1; the first frame subtracts itself to get zero
        op_a  <= stamp.timestamp_ns;
        op_b  <= seen_first ? ~last_stamp : ~stamp.timestamp_ns;
        carry <= 1'b1;
        dcnt  <= '0;
        steps <= '0;
        hitch <= 1'b0;
      end
      ST_DELTA, ST_TOTAL: begin
        op_a  <= op_a_next;
        op_b  <= op_b >> DIGIT_W;
        carry <= dsum[DIGIT_W];
        dcnt  <= dcnt + 1'b1;
      end
      ST_CLAMP: begin
        raw <= raw_c;
        dt  <= (raw_c < limit_c) ? raw_c : limit_c;
      end
      ST_STATS: begin
        op_a  <= run_time;
        op_b  <= {{(STAMP_W-DT_W){1'b0}}, dt};
        carry <= 1'b0;
        dcnt  <= '0;
      end
      ST_RATE_WAIT: begin
        if (div_done) begin
          inst <= (|div_quo[NUM_W-1:RATE_W]) ? RATE_MAX : div_quo[RATE_W-1:0];
        end
      end
      ST_STEP_SUM: begin
        acc <= {1'b0, step_accumulator} + {2'b00, dt};
        cap <= ({3'b000, target} << 2) + {3'b000, target};
      end
      ST_STEP_CLIP: begin
        if (acc > {1'b0, cap}) begin
          acc   <= {1'b0, cap};
          hitch <= 1'b1;
        end
      end
      ST_STEP_DRAIN: begin
        if (acc >= {4'b0000, target}) begin
          acc   <= acc - {4'b0000, target};
          steps <= steps + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_OUTPUT && (!res_valid || result.ready)) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUTPUT && (!res_valid || result.ready)) begin
      res.frame_dt_ns      <= dt;
      res.raw_dt_ns        <= raw;
      res.smoothed_rate_q8 <= rate_avg;
      res.min_dt_ns        <= min_interval;
      res.max_dt_ns        <= max_interval;
      res.avg_dt_ns        <= interval_avg;
      res.total_time_ns    <= run_time;
      res.frame_number     <= frames_seen;
      res.fixed_steps      <= steps;
      res.hitch            <= hitch;
    end
  end

  assign result.valid            = res_valid;
  assign result.frame_dt_ns      = res.frame_dt_ns;
  assign result.raw_dt_ns        = res.raw_dt_ns;
  assign result.smoothed_rate_q8 = res.smoothed_rate_q8;
  assign result.min_dt_ns        = res.min_dt_ns;
  assign result.max_dt_ns        = res.max_dt_ns;
  assign result.avg_dt_ns        = res.avg_dt_ns;
  assign result.total_time_ns    = res.total_time_ns;
  assign result.frame_number     = res.frame_number;
  assign result.fixed_steps      = res.fixed_steps;
  assign result.hitch            = res.hitch;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // an accepted word starts the interval subtraction
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    stamp.valid && stamp.ready |=> state == ST_DELTA)
    else $error("accepted word did not start the interval subtraction");

  // a clamped accumulator always drains exactly five periods
  a_hitch_steps: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hitch |-> result.fixed_steps == MAX_STEPS)
    else $error("hitch without five fixed steps");

  // once a word has been delivered the minimum never exceeds the maximum
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.min_dt_ns <= result.max_dt_ns)
    else $error("minimum interval above maximum interval");

  // divider results only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_RATE_WAIT || state == ST_RAVG_WAIT ||
                  state == ST_IAVG_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule
